FILE: design/paged_bump_allocator_macros.svh
`ifndef PAGED_BUMP_ALLOCATOR_MACROS_SVH
`define PAGED_BUMP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("paged_bump_allocator: assertion failed");

// Next-cycle implication, checked out of reset.
`define PBA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("paged_bump_allocator: assertion failed");

`endif

FILE: design/pba_pkg.sv
package pba_pkg;

    localparam int FILL_W   = 17;
    localparam int HDR_W    = 8;
    localparam int PAGE_W   = 4;
    localparam int OFFS_W   = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [FILL_W-1:0] PAGE_SIZE_RESET = 17'd4096;
    localparam logic [HDR_W-1:0]  HEADER_RESET    = 8'd24;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 1'b1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PAGE   = 2'd2;

    typedef struct packed {
        logic              op;
        logic [FILL_W-1:0] req_size;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   grant_page;
        logic [OFFS_W-1:0]   grant_offset;
    } out_t;

    typedef struct packed {
        logic [FILL_W-1:0] page_size;
        logic [HDR_W-1:0]  header_bytes;
    } cfg_t;

endpackage

FILE: design/pba_fill_ram.sv
module pba_fill_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 17
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/pba_ctrl.sv
module pba_ctrl #(
    parameter int MAX_PAGES = 16,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pba_pkg::cfg_t        cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pba_pkg::in_t         s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pba_pkg::out_t        m_data,
    output logic                 ram_wr_en,
    output logic [IDX_W-1:0]     ram_wr_addr,
    output logic [pba_pkg::FILL_W-1:0] ram_wr_data,
    output logic                 ram_rd_en,
    output logic [IDX_W-1:0]     ram_rd_addr,
    input  logic [pba_pkg::FILL_W-1:0] ram_rd_data
);
    import pba_pkg::*;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  req_reg, req_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    out_t               res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic [FILL_W-1:0]       hdr_ext;
    logic [FILL_W-1:0]       usable;
    logic                    too_large;
    logic [CNT_W-1:0]        used_m1;
    logic [FILL_W-1:0]       room;
    logic                    fits;
    logic [PAGE_W+IDX_W-1:0] idx_page_ext;
    logic [PAGE_W+CNT_W-1:0] used_page_ext;

    assign hdr_ext   = {{(FILL_W-HDR_W){1'b0}}, cfg.header_bytes};
    assign usable    = (cfg.page_size > hdr_ext) ? cfg.page_size - hdr_ext : '0;
    assign too_large = s_data.req_size > usable;
    assign used_m1   = used_reg - CNT_W'(1);
    assign room      = (cfg.page_size > ram_rd_data) ? cfg.page_size - ram_rd_data : '0;
    assign fits      = req_reg <= room;

    assign idx_page_ext  = {{PAGE_W{1'b0}}, idx_reg};
    assign used_page_ext = {{PAGE_W{1'b0}}, used_reg};

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        idx_next     = idx_reg;
        used_next    = used_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = '0;
        ram_wr_data  = '0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT: begin
                // page 0 opens with the reset header
                ram_wr_en   = 1'b1;
                ram_wr_data = {{(FILL_W-HDR_W){1'b0}}, HEADER_RESET};
                state_next  = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_data.req_size;
                    if (s_data.op == OP_RELEASE) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = hdr_ext;
                        used_next   = CNT_W'(1);
                        res_next    = '{status: ST_OK, grant_page: '0, grant_offset: '0};
                        state_next  = S_DONE;
                    end else if (too_large) begin
                        res_next   = '{status: ST_TOO_LARGE, grant_page: '0,
                                       grant_offset: '0};
                        state_next = S_DONE;
                    end else begin
                        // start with the newest page
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = used_m1[IDX_W-1:0];
                        idx_next    = used_m1[IDX_W-1:0];
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (fits) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = idx_reg;
                    ram_wr_data = ram_rd_data + req_reg;
                    res_next    = '{status: ST_OK, grant_page: idx_page_ext[PAGE_W-1:0],
                                    grant_offset: ram_rd_data[OFFS_W-1:0]};
                    state_next  = S_DONE;
                end else if (idx_reg == '0) begin
                    if (used_reg == CNT_W'(MAX_PAGES)) begin
                        res_next = '{status: ST_NO_PAGE, grant_page: '0,
                                     grant_offset: '0};
                    end else begin
                        // open a fresh page
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = used_reg[IDX_W-1:0];
                        ram_wr_data = hdr_ext + req_reg;
                        used_next   = used_reg + CNT_W'(1);
                        res_next    = '{status: ST_OK,
                                        grant_page: used_page_ext[PAGE_W-1:0],
                                        grant_offset: {{(OFFS_W-HDR_W){1'b0}},
                                                       cfg.header_bytes}};
                    end
                    state_next = S_DONE;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_reg - IDX_W'(1);
                    idx_next    = idx_reg - IDX_W'(1);
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            used_reg    <= CNT_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: design/paged_bump_allocator.sv
// Release and too-large: the result is registered and waits in S_DONE until the output
// register is free; s_ready stays low until the return to S_IDLE.
// Allocate visits k pages (k = 1..pages open, opening a page visits all) in S_SCAN, where
// the fill RAM read port checks one page per cycle, newest first, before S_DONE.
// Reset: synchronous active-low; after reset the S_INIT state writes page 0's fill with
// the reset header before the first transaction; config registers take reset values.
`include "paged_bump_allocator_macros.svh"

module paged_bump_allocator #(
    parameter int MAX_PAGES = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  pba_pkg::in_t                     s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output pba_pkg::out_t                    m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pba_pkg::FILL_W-1:0]       cfg_data
);
    import pba_pkg::*;

    localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W = $clog2(MAX_PAGES + 1);

    cfg_t               cfg_reg, cfg_next;
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [FILL_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [FILL_W-1:0]  ram_rd_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_PAGE_SIZE:    cfg_next.page_size    = cfg_data;
                CFG_HEADER_BYTES: cfg_next.header_bytes = cfg_data[HDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{page_size: PAGE_SIZE_RESET, header_bytes: HEADER_RESET};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pba_ctrl #(
        .MAX_PAGES (MAX_PAGES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    pba_fill_ram #(
        .DEPTH (MAX_PAGES),
        .AW    (IDX_W),
        .DW    (FILL_W)
    ) u_fill_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    `PBA_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `PBA_ASSERT_IMP(a_ram_no_overlap, aclk, aresetn, ram_wr_en, !ram_rd_en)
    `PBA_ASSERT_IMP(a_fail_zero_grant, aclk, aresetn, m_valid && (m_data.status != ST_OK), (m_data.grant_page == '0) && (m_data.grant_offset == '0))

endmodule
